// ----- hw/rtl/imufd_pkg.sv -----
`timescale 1ns / 1ps

package imufd_pkg;

    // Frame framing and type codes
    localparam logic [7:0] HeaderByte = 8'h55;
    localparam logic [7:0] TypeAccel  = 8'h51;
    localparam logic [7:0] TypeAngle  = 8'h53;

    // Bytes 0..10 of a frame; the checksum byte sits at the last position
    localparam int unsigned FrameLen = 11;
    localparam int unsigned PosW     = 4;
    localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

    // Result field widths
    localparam int unsigned AxisW = 17;
    localparam int unsigned TempW = 18;
    localparam int unsigned DataW = 72;   // 3*17 + 18 = 69, padded to bytes

    // Result kind flag carried in tuser
    localparam logic KindAccel = 1'b0;
    localparam logic KindAngle = 1'b1;

    // floor(raw*49/40): offset to a multiple of 40, then reciprocal multiply.
    // u = raw + 32800 lies in [32, 65567]; 49*ceil(2^28/40) = 328833463.
    localparam logic [16:0] AccOffset = 17'd32800;
    localparam logic [28:0] AccMult   = 29'd328833463;
    localparam logic [17:0] AccBias   = 18'd40180;

    // floor(raw*64/25): u = raw + 32775 in [7, 65542]; ceil(2^28/25) = 10737419,
    // the factor 64 folds into the shift (28 - 6 = 22).
    localparam logic [16:0] TmpOffset = 17'd32775;
    localparam logic [23:0] TmpMult   = 24'd10737419;
    localparam logic [18:0] TmpBias   = 19'd83904;

    function automatic logic [AxisW-1:0] scale_accel(input logic [15:0] raw);
        logic [16:0] u;
        logic [45:0] prod;
        logic [17:0] q;
        logic [17:0] d;
        u    = {1'b0, raw ^ 16'h8000} + (AccOffset - 17'd32768);
        prod = 46'(u) * 46'(AccMult);
        q    = prod[45:28];
        d    = q - AccBias;
        return d[AxisW-1:0];
    endfunction

    function automatic logic [AxisW-1:0] scale_angle(input logic [15:0] raw);
        logic signed [21:0] prod;
        prod = 22'($signed(raw)) * 22'sd45;
        return prod[21:5];   // arithmetic shift by 5: floor(raw*45/32)
    endfunction

    function automatic logic [TempW-1:0] scale_temp(input logic [15:0] raw);
        logic [16:0] u;
        logic [40:0] prod;
        logic [18:0] q;
        logic [18:0] d;
        u    = {1'b0, raw ^ 16'h8000} + (TmpOffset - 17'd32768);
        prod = 41'(u) * 41'(TmpMult);
        q    = prod[40:22];
        d    = q - TmpBias;
        return d[TempW-1:0];
    endfunction

endpackage

// ----- hw/rtl/imu_frame_decoder_top.sv -----
`timescale 1ns / 1ps

// IMU serial frame decoder.
// s_ channel: one received link byte per transaction in s_tdata[7:0].
// m_ channel: one decoded frame per transaction. m_tuser is the frame kind
// (0 acceleration, 1 angle); m_tdata carries the three scaled axes and the
// temperature, all signed Q8.
// Bytes before a 0x55 header are dropped; the header starts an 11-byte frame
// and the eleventh (checksum, unchecked) byte triggers the decode. Frames of
// type 0x51 or 0x53 give a result, any other type gives none.
// Throughput: one byte per cycle while s_tready is high. Latency: the result
// is valid in the cycle after the checksum byte is taken; scaling is one
// constant multiply per field between the frame store and the output register.
// The output register lets bytes keep flowing while a result waits; s_tready
// drops only when a checksum byte would arrive while the previous result is
// still stalled by m_tready.
// Reset (aresetn low, synchronous) returns the parser to header search and
// empties the output register.
module imu_frame_decoder_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [imufd_pkg::DataW-1:0] m_tdata,   // [16:0] axis_x, [33:17] axis_y,
                                                   // [50:34] axis_z, [68:51] temperature
    output logic                        m_tuser    // [0] frame_kind
);
    import imufd_pkg::*;

    logic [PosW-1:0]  pos_reg, pos_next;
    logic [7:0]       store_reg [1:FrameLen-2];
    logic             vld_reg, vld_next;
    logic             kind_reg;
    logic [AxisW-1:0] ax_reg, ay_reg, az_reg;
    logic [TempW-1:0] temp_reg;

    logic             s_hs;
    logic             last_byte;
    logic             is_accel, is_angle;
    logic             load;
    logic [AxisW-1:0] ax_c, ay_c, az_c;
    logic [TempW-1:0] temp_c;

    // Handshake: stall only a checksum byte that would overwrite a held result
    assign s_tready  = !(vld_reg && !m_tready && (pos_reg == LastPos));
    assign s_hs      = s_tvalid && s_tready;
    assign last_byte = (pos_reg == LastPos);

    // Frame type decode
    assign is_accel = (store_reg[1] == TypeAccel);
    assign is_angle = (store_reg[1] == TypeAngle);
    assign load     = s_hs && last_byte && (is_accel || is_angle);

    // Scaling of the stored readings
    always_comb begin
        if (is_angle) begin
            ax_c   = scale_angle({store_reg[2], store_reg[3]});
            ay_c   = scale_angle({store_reg[4], store_reg[5]});
            az_c   = scale_angle({store_reg[6], store_reg[7]});
            temp_c = '0;
        end else begin
            ax_c   = scale_accel({store_reg[2], store_reg[3]});
            ay_c   = scale_accel({store_reg[4], store_reg[5]});
            az_c   = scale_accel({store_reg[6], store_reg[7]});
            temp_c = scale_temp({store_reg[8], store_reg[9]});
        end
    end

    // Byte position
    always_comb begin
        pos_next = pos_reg;
        if (s_hs) begin
            if (pos_reg == '0) begin
                if (s_tdata == HeaderByte) begin
                    pos_next = PosW'(1);
                end
            end else if (last_byte) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + PosW'(1);
            end
        end
    end

    // Output valid
    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            vld_reg <= vld_next;
        end
    end

    // Frame store, one fixed slot per byte position from the type byte to the last data byte
    always_ff @(posedge aclk) begin
        for (int i = 1; i <= FrameLen - 2; i++) begin
            if (s_hs && (pos_reg == PosW'(i))) begin
                store_reg[i] <= s_tdata;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= is_angle ? KindAngle : KindAccel;
            ax_reg   <= ax_c;
            ay_reg   <= ay_c;
            az_reg   <= az_c;
            temp_reg <= temp_c;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {3'b000, temp_reg, az_reg, ay_reg, ax_reg};

    // Checks
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= LastPos)
        else $error("byte position beyond frame length");

    a_hunt_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_hs && (pos_reg == '0) && (s_tdata != HeaderByte)) |=> (pos_reg == '0))
        else $error("non-header byte left header search");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(vld_reg) |-> $past(s_hs && last_byte))
        else $error("result without a completed frame");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && !m_tready) |=> vld_reg)
        else $error("held result dropped");

    a_angle_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && (kind_reg == KindAngle)) |-> (temp_reg == '0))
        else $error("angle frame with non-zero temperature");

endmodule

// ----- bench/imu_frame_decoder_checker.sv -----
`timescale 1ns / 1ps

module imu_frame_decoder_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [imufd_pkg::DataW-1:0] m_tdata,
    input  logic                        m_tuser,
    output int                          fail_count,
    output int                          pending
);
    import imufd_pkg::*;

    // One decoded frame as it should leave the block
    typedef struct {
        logic                    kind;
        logic signed [AxisW-1:0] axis_x;
        logic signed [AxisW-1:0] axis_y;
        logic signed [AxisW-1:0] axis_z;
        logic signed [TempW-1:0] temperature;
    } frame_reading_t;

    frame_reading_t    frames_due[$];
    logic [PosW-1:0]   byte_pos;
    logic [7:0]        frame_buf [0:FrameLen-2];

    // Scaling that rounds toward minus infinity
    function automatic longint floor_ratio(input longint raw, input longint mul,
                                           input longint div);
        longint p;
        longint q;
        p = raw * mul;
        q = p / div;
        if (p % div != 0 && p < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Big-endian signed 16-bit word from the frame buffer
    function automatic longint be_word(input int hi);
        return longint'($signed({frame_buf[hi], frame_buf[hi+1]}));
    endfunction

    // Parser model: one accepted link byte
    task automatic take_link_byte(input logic [7:0] b);
        frame_reading_t r;
        longint         mul;
        longint         div;
        if (byte_pos == '0 && b != HeaderByte) begin
            return;
        end
        if (byte_pos < LastPos) begin
            frame_buf[byte_pos] = b;
            byte_pos = byte_pos + 1'b1;
            return;
        end
        // checksum byte: decode, back to header search
        byte_pos = '0;
        if (frame_buf[1] == TypeAccel) begin
            mul = 49;
            div = 40;
            r.kind = KindAccel;
            r.temperature = TempW'(floor_ratio(be_word(8), 64, 25));
        end else if (frame_buf[1] == TypeAngle) begin
            mul = 45;
            div = 32;
            r.kind = KindAngle;
            r.temperature = '0;
        end else begin
            return;
        end
        r.axis_x = AxisW'(floor_ratio(be_word(2), mul, div));
        r.axis_y = AxisW'(floor_ratio(be_word(4), mul, div));
        r.axis_z = AxisW'(floor_ratio(be_word(6), mul, div));
        frames_due.push_back(r);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result side first, then the byte taken at the same edge
    always @(posedge aclk) begin
        frame_reading_t r;
        if (!aresetn) begin
            byte_pos = '0;
            foreach (frame_buf[i]) frame_buf[i] = '0;
            frames_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (frames_due.size() == 0) begin
                    $error("result transaction with no decoded frame outstanding");
                    fail_count++;
                end else begin
                    r = frames_due.pop_front();
                    check_field("frame_kind", r.kind, m_tuser);
                    check_field("axis_x", r.axis_x, $signed(m_tdata[16:0]));
                    check_field("axis_y", r.axis_y, $signed(m_tdata[33:17]));
                    check_field("axis_z", r.axis_z, $signed(m_tdata[50:34]));
                    check_field("temperature", r.temperature, $signed(m_tdata[68:51]));
                end
            end
            if (s_tvalid && s_tready) begin
                take_link_byte(s_tdata);
            end
        end
        pending = frames_due.size();
    end

endmodule

// ----- bench/tb_imu_frame_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_imu_frame_decoder_top;
    import imufd_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int HoldCycles    = 300;
    localparam int PhaseFrames   = 26;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [DataW-1:0] m_tdata;
    logic             m_tuser;

    int   fail_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles   = 0;
    logic holding        = 1'b0;
    event hold_off_ev;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    imu_frame_decoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    imu_frame_decoder_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random back-pressure, or a long hold-off on request
    always @(negedge aclk) begin
        m_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    always begin
        @(hold_off_ev);
        @(posedge aclk);
        holding = 1'b1;
        repeat (HoldCycles) @(posedge aclk);
        holding = 1'b0;
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchdogLimit) begin
            $display("imu_frame_decoder_top test failed");
            $finish;
        end
    end

    // One link byte; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] kind_byte, input logic [15:0] x,
                              input logic [15:0] y, input logic [15:0] z,
                              input logic [15:0] temp, input logic [7:0] csum);
        send_byte(HeaderByte);
        send_byte(kind_byte);
        send_byte(x[15:8]);
        send_byte(x[7:0]);
        send_byte(y[15:8]);
        send_byte(y[7:0]);
        send_byte(z[15:8]);
        send_byte(z[7:0]);
        send_byte(temp[15:8]);
        send_byte(temp[7:0]);
        send_byte(csum);
    endtask

    // Raw readings lean towards the range ends and zero
    function automatic logic [15:0] pick_reading();
        case ($urandom_range(11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h8001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_kind_byte();
        case ($urandom_range(9)) inside
            [0:3]:   return TypeAccel;
            [4:7]:   return TypeAngle;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly clean frames, with line noise and cut-off frames mixed in
    task automatic random_frames(input int n);
        repeat (n) begin
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end
            if ($urandom_range(99) < 5) begin
                send_byte(HeaderByte);
                repeat ($urandom_range(1, 9)) send_byte(8'($urandom_range(255)));
            end
            send_frame(pick_kind_byte(), pick_reading(), pick_reading(), pick_reading(),
                       pick_reading(), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: idle noise, range ends, header value inside a frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(TypeAccel, 16'h8000, 16'h7FFF, 16'h5555, 16'h8000, HeaderByte);
        send_frame(TypeAngle, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 8'h00);

        // No idling, then a long receiver hold-off with the sender pushing on
        random_frames(PhaseFrames);
        -> hold_off_ev;
        repeat (5) begin
            send_frame(TypeAccel, pick_reading(), pick_reading(), pick_reading(),
                       pick_reading(), 8'($urandom_range(255)));
        end

        send_idle_pct  = 60;
        recv_stall_pct = 0;
        random_frames(PhaseFrames);

        send_idle_pct  = 0;
        recv_stall_pct = 60;
        random_frames(PhaseFrames);

        send_idle_pct  = 12;
        recv_stall_pct = 12;
        random_frames(PhaseFrames);

        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("imu_frame_decoder_top test passed");
        end else begin
            $display("imu_frame_decoder_top test failed");
        end
        $finish;
    end

endmodule
